/* rtl/button_press_classifier_top_assert.svh */
// Assertion macros for the button press classifier top level.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define BPC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
// Shared constants, types and helpers for the button press classifier.
// No dependencies.
package bpc_pkg;

  localparam int SLOTS       = 3;   // button fields on the ports
  localparam int NUM_BUTTONS = 3;   // buttons evaluated, 2 or 3
  localparam int TIMER_BITS  = 17;  // elapsed timer width, 8..32
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int EV_W        = 2;
  localparam int CMP_W       = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [EV_W-1:0]       event_t;

  localparam event_t EV_NONE  = 2'd0;
  localparam event_t EV_SHORT = 2'd1;
  localparam event_t EV_LONG  = 2'd2;

  localparam cfg_idx_t REG_LONG_PRESS = 1'd0;
  localparam cfg_idx_t REG_LOCKOUT    = 1'd1;

  localparam cfg_data_t LONG_PRESS_RESET = 16'd2000;
  localparam cfg_data_t LOCKOUT_RESET    = 16'd500;

  // Saturating increment.
  function automatic timer_t timer_tick(input timer_t t);
    return (t == '1) ? t : timer_t'(t + 1'b1);
  endfunction

  // a > b with both sides widened to a common width.
  function automatic logic timer_gt(input timer_t a, input cfg_data_t b);
    return CMP_W'(a) > CMP_W'(b);
  endfunction

  function automatic logic timer_lt(input timer_t a, input cfg_data_t b);
    return CMP_W'(a) < CMP_W'(b);
  endfunction

endpackage

/* rtl/bpc_if.sv */
// Channel interfaces for the button press classifier.
// Depends on bpc_pkg.
interface bpc_button_if;
  logic valid;
  logic ready;
  logic left_pressed;
  logic middle_pressed;
  logic right_pressed;
  modport source (output valid, left_pressed, middle_pressed, right_pressed, input ready);
  modport sink   (input valid, left_pressed, middle_pressed, right_pressed, output ready);
endinterface

interface bpc_event_if;
  logic            valid;
  logic            ready;
  bpc_pkg::event_t left_event;
  bpc_pkg::event_t middle_event;
  bpc_pkg::event_t right_event;
  modport source (output valid, left_event, middle_event, right_event, input ready);
  modport sink   (input valid, left_event, middle_event, right_event, output ready);
endinterface

interface bpc_cfg_if;
  logic                 valid;
  logic                 ready;
  bpc_pkg::cfg_idx_t    index;
  bpc_pkg::cfg_data_t   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/button_press_classifier_top.sv */
// Button press classifier top level: per-button arming, short/long press
// detection and lockout. Depends on bpc_pkg, bpc_if.sv and the assert header.
//
//  channel  | dir | payload                                     | handshake
//  ---------+-----+---------------------------------------------+-----------
//  buttons  | in  | left/middle/right_pressed, one request/tick | valid/ready
//  events   | out | left/middle/right_event (0 none,1 short,2 long) | valid/ready
//  cfg      | in  | index (0 long_press_ticks, 1 lockout_ticks), data | valid/ready
//
// One request per clock unless stalled; the output register holds its events.
// A request is taken whenever the output register is empty or being drained.
// A stall on events holds the result and backs up buttons; nothing is dropped.
// rst (synchronous) clears all button state and loads 2000 / 500 into the registers.
// cfg is always ready; writes take effect on the next request.

`include "button_press_classifier_top_assert.svh"

module button_press_classifier_top (
  input  logic               clk,
  input  logic               rst,
  bpc_button_if.sink         buttons,
  bpc_event_if.source        events,
  bpc_cfg_if.sink            cfg
);

  // Configuration registers
  bpc_pkg::cfg_data_t long_press_ticks;
  bpc_pkg::cfg_data_t lockout_ticks;

  // Per-button state
  logic [bpc_pkg::SLOTS-1:0] armed, armed_next;
  logic [bpc_pkg::SLOTS-1:0] held, held_next;
  logic [bpc_pkg::SLOTS-1:0] lock, lock_next;
  bpc_pkg::timer_t           press_elapsed [bpc_pkg::SLOTS];
  bpc_pkg::timer_t           press_elapsed_next [bpc_pkg::SLOTS];
  bpc_pkg::timer_t           release_elapsed [bpc_pkg::SLOTS];
  bpc_pkg::timer_t           release_elapsed_next [bpc_pkg::SLOTS];

  // Result register
  logic                      out_valid;
  bpc_pkg::event_t           ev_next [bpc_pkg::SLOTS];
  bpc_pkg::event_t           ev_reg  [bpc_pkg::SLOTS];
  logic [bpc_pkg::SLOTS-1:0] long_mask;

  logic                      in_accept;
  logic [bpc_pkg::SLOTS-1:0] lvl;

  assign lvl          = {buttons.right_pressed, buttons.middle_pressed, buttons.left_pressed};
  assign buttons.ready = !out_valid || events.ready;
  assign in_accept    = buttons.valid && buttons.ready;
  assign cfg.ready    = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= bpc_pkg::LONG_PRESS_RESET;
      lockout_ticks    <= bpc_pkg::LOCKOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bpc_pkg::REG_LONG_PRESS: long_press_ticks <= cfg.data;
        bpc_pkg::REG_LOCKOUT:    lockout_ticks    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Per-button classification: timers advance first, then arm, short,
  // long, and otherwise release tracking and unlock.
  always_comb begin
    logic             others_free;
    bpc_pkg::timer_t  pe;
    bpc_pkg::timer_t  re;
    logic             arm;
    for (int b = 0; b < bpc_pkg::SLOTS; b++) begin
      armed_next[b]           = armed[b];
      held_next[b]            = held[b];
      lock_next[b]            = lock[b];
      press_elapsed_next[b]   = press_elapsed[b];
      release_elapsed_next[b] = release_elapsed[b];
      ev_next[b]              = bpc_pkg::EV_NONE;
      long_mask[b]            = 1'b0;
      others_free             = 1'b1;
      pe                      = press_elapsed[b];
      re                      = release_elapsed[b];
      arm                     = armed[b];
      if (b < bpc_pkg::NUM_BUTTONS) begin
        for (int j = 0; j < bpc_pkg::NUM_BUTTONS; j++) begin
          if (j != b && lvl[j]) others_free = 1'b0;
        end
        pe = bpc_pkg::timer_tick(press_elapsed[b]);
        re = bpc_pkg::timer_tick(release_elapsed[b]);
        if (lvl[b] && !armed[b] && !lock[b] && others_free) begin
          arm = 1'b1;
          pe  = '0;
        end
        if (arm && bpc_pkg::timer_lt(pe, long_press_ticks) && !lvl[b] && !lock[b]) begin
          arm        = 1'b0;
          ev_next[b] = bpc_pkg::EV_SHORT;
        end else if (arm && bpc_pkg::timer_gt(pe, long_press_ticks) && !lock[b]) begin
          arm          = 1'b0;
          held_next[b] = 1'b1;
          lock_next[b] = 1'b1;
          ev_next[b]   = bpc_pkg::EV_LONG;
          long_mask[b] = 1'b1;
        end else begin
          if (held[b] && !lvl[b]) begin
            held_next[b] = 1'b0;
            re           = '0;
          end
          if (!held_next[b] && bpc_pkg::timer_gt(re, lockout_ticks)) lock_next[b] = 1'b0;
        end
        armed_next[b]           = arm;
        press_elapsed_next[b]   = pe;
        release_elapsed_next[b] = re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      held  <= '0;
      lock  <= '0;
      for (int b = 0; b < bpc_pkg::SLOTS; b++) begin
        press_elapsed[b]   <= '0;
        release_elapsed[b] <= '0;
      end
    end else if (in_accept) begin
      armed <= armed_next;
      held  <= held_next;
      lock  <= lock_next;
      for (int b = 0; b < bpc_pkg::SLOTS; b++) begin
        press_elapsed[b]   <= press_elapsed_next[b];
        release_elapsed[b] <= release_elapsed_next[b];
      end
    end
  end

  // Output register: loads on accept, clears when drained with no new request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int b = 0; b < bpc_pkg::SLOTS; b++) ev_reg[b] <= ev_next[b];
    end
  end

  assign events.valid        = out_valid;
  assign events.left_event   = ev_reg[0];
  assign events.middle_event = ev_reg[1];
  assign events.right_event  = ev_reg[2];

  // Checks
  `BPC_ASSERT_ALWAYS(a_armed_not_locked, (armed & lock) == '0, "button armed while locked out")
  `BPC_ASSERT_ALWAYS(a_held_implies_lock, (held & ~lock) == '0, "held lock without lockout")
  `BPC_ASSERT_ALWAYS(a_unused_idle, (armed[bpc_pkg::SLOTS-1] == 1'b0) || (bpc_pkg::NUM_BUTTONS == bpc_pkg::SLOTS), "unused button armed")
  `BPC_ASSERT_NEXT(a_long_locks, in_accept && (long_mask != '0), (lock & $past(long_mask)) == $past(long_mask), "long press did not lock")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for button_press_classifier_top: drives button samples,
// predicts the per-button short/long events and checks every result in order.
// Depends on bpc_pkg, the channel interfaces in bpc_if.sv and the RTL top level.
module tb;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int DRAIN_TAIL   = 4;          // result register is one stage deep
  localparam int RANDOM_ITEMS = 1200;
  localparam int REPORT_CAP   = 20;

  // One request: sampled pressed levels. One result: event code per button.
  typedef struct packed {
    logic left;
    logic middle;
    logic right;
  } press_t;

  typedef struct packed {
    bpc_pkg::event_t left;
    bpc_pkg::event_t middle;
    bpc_pkg::event_t right;
  } events_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  bpc_button_if btn_if ();
  bpc_event_if  ev_if ();
  bpc_cfg_if    cfg_if ();

  button_press_classifier_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .buttons(btn_if),
    .events (ev_if),
    .cfg    (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and per-button timers.
  // ---------------------------------------------------------------------------
  bpc_pkg::cfg_data_t long_limit;
  bpc_pkg::cfg_data_t lockout_limit;

  logic            armed           [bpc_pkg::SLOTS];  // press qualified, timing its hold
  bpc_pkg::timer_t held_ticks      [bpc_pkg::SLOTS];  // ticks since arming, saturating
  logic            held_after_long [bpc_pkg::SLOTS];  // long seen, button still down
  logic            lockout_on      [bpc_pkg::SLOTS];
  bpc_pkg::timer_t since_release   [bpc_pkg::SLOTS];  // ticks since release after long

  events_t events_due[$];           // expected results, oldest first

  int    errors         = 0;
  int    presses_sent   = 0;
  int    events_checked = 0;
  int    src_idle_pct   = 0;
  int    snk_stall_pct  = 0;
  int    hold_off_left  = 0;        // long receiver hold-off, counted down below
  longint cycles        = 0;

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Advance the button model by one tick and return the events it raises.
  function automatic events_t predict_events(press_t p);
    logic            lvl [bpc_pkg::SLOTS];
    bpc_pkg::event_t ev  [bpc_pkg::SLOTS];
    logic            others_down;
    lvl[0] = p.left;
    lvl[1] = p.middle;
    lvl[2] = p.right;
    for (int b = 0; b < bpc_pkg::SLOTS; b++) ev[b] = bpc_pkg::EV_NONE;
    // Both timers run every tick, saturating at all ones.
    for (int b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin
      if (held_ticks[b] != '1) held_ticks[b] = held_ticks[b] + 1'b1;
      if (since_release[b] != '1) since_release[b] = since_release[b] + 1'b1;
    end
    for (int b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin
      others_down = 1'b0;
      for (int j = 0; j < bpc_pkg::NUM_BUTTONS; j++)
        if (j != b && lvl[j]) others_down = 1'b1;
      if (lvl[b] && !armed[b] && !lockout_on[b] && !others_down) begin
        armed[b]      = 1'b1;
        held_ticks[b] = '0;
      end
      if (armed[b] && held_ticks[b] < long_limit && !lvl[b] && !lockout_on[b]) begin
        armed[b] = 1'b0;
        ev[b]    = bpc_pkg::EV_SHORT;
      end else if (armed[b] && held_ticks[b] > long_limit && !lockout_on[b]) begin
        armed[b]           = 1'b0;
        held_after_long[b] = 1'b1;
        lockout_on[b]      = 1'b1;
        ev[b]              = bpc_pkg::EV_LONG;
      end else begin
        if (held_after_long[b] && !lvl[b]) begin
          held_after_long[b] = 1'b0;
          since_release[b]   = '0;
        end
        if (!held_after_long[b] && since_release[b] > lockout_limit)
          lockout_on[b] = 1'b0;
      end
    end
    return '{left: ev[0], middle: ev[1], right: ev[2]};
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. valid stays high from one request to the next unless an idle
  // gap is rolled; callers drop it through drain_events when a burst ends.
  // ---------------------------------------------------------------------------
  task automatic send_press(press_t p);
    if (roll(src_idle_pct)) begin
      btn_if.valid <= 1'b0;
      do @(posedge clk); while (roll(src_idle_pct));
    end
    btn_if.valid          <= 1'b1;
    btn_if.left_pressed   <= p.left;
    btn_if.middle_pressed <= p.middle;
    btn_if.right_pressed  <= p.right;
    do @(posedge clk); while (!btn_if.ready);
    events_due.push_back(predict_events(p));
    presses_sent++;
  endtask

  task automatic hold_pattern(press_t p, int ticks);
    repeat (ticks) send_press(p);
  endtask

  task automatic drain_events();
    btn_if.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Both registers are written back to back once the block has gone quiet.
  task automatic set_timing(bpc_pkg::cfg_data_t long_ticks, bpc_pkg::cfg_data_t lock_ticks);
    drain_events();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= bpc_pkg::REG_LONG_PRESS;
    cfg_if.data  <= long_ticks;
    do @(posedge clk); while (!cfg_if.ready);
    long_limit = long_ticks;
    cfg_if.index <= bpc_pkg::REG_LOCKOUT;
    cfg_if.data  <= lock_ticks;
    do @(posedge clk); while (!cfg_if.ready);
    lockout_limit = lock_ticks;
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, plus a counted hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      ev_if.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      ev_if.ready   <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      ev_if.ready <= !roll(snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    events_t want;
    if (!rst && ev_if.valid && ev_if.ready) begin
      if (events_due.size() == 0) begin
        report_error("event result with no request outstanding");
      end else begin
        want = events_due.pop_front();
        events_checked++;
        if (ev_if.left_event !== want.left)
          report_error($sformatf("left_event got %0d want %0d",
                                 ev_if.left_event, want.left));
        if (ev_if.middle_event !== want.middle)
          report_error($sformatf("middle_event got %0d want %0d",
                                 ev_if.middle_event, want.middle));
        if (ev_if.right_event !== want.right)
          report_error($sformatf("right_event got %0d want %0d",
                                 ev_if.right_event, want.right));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  localparam press_t NONE   = 3'b000;
  localparam press_t LEFT   = 3'b100;
  localparam press_t MIDDLE = 3'b010;
  localparam press_t RIGHT  = 3'b001;

  // Reset values 2000 / 500 are used before any register write.
  task automatic test_reset_timing();
    hold_pattern(LEFT, 5);
    hold_pattern(NONE, 1);      // short
    hold_pattern(MIDDLE, 60);   // still far below 2000 ticks
    hold_pattern(NONE, 1);      // short
  endtask

  task automatic test_directed();
    set_timing(16'd5, 16'd3);
    // plain short press on each button
    hold_pattern(LEFT, 3);   hold_pattern(NONE, 2);
    hold_pattern(MIDDLE, 3); hold_pattern(NONE, 2);
    hold_pattern(RIGHT, 3);  hold_pattern(NONE, 2);
    // release with elapsed exactly at the limit: silent, long on the next tick
    hold_pattern(LEFT, 5);   hold_pattern(NONE, 8);
    // two buttons together: neither arms
    hold_pattern(LEFT | MIDDLE, 4); hold_pattern(NONE, 2);
    // left armed first, middle joins late; left lets go right at the limit
    // and turns long a tick later, middle arms once alone and ends short
    hold_pattern(LEFT, 2); hold_pattern(LEFT | MIDDLE, 3);
    hold_pattern(MIDDLE, 2); hold_pattern(NONE, 2);
    // long press, then a re-press inside the lockout window is ignored
    hold_pattern(RIGHT, 8); hold_pattern(NONE, 1);
    hold_pattern(RIGHT, 2); hold_pattern(NONE, 6);
    hold_pattern(RIGHT, 2); hold_pattern(NONE, 1);
    // keep holding past the long event while another button is pressed
    hold_pattern(MIDDLE, 9); hold_pattern(MIDDLE | RIGHT, 2);
    hold_pattern(NONE, 6);
    // every level pattern once
    for (int v = 0; v < 8; v++) send_press(press_t'(v));
    hold_pattern(NONE, 6);
  endtask

  task automatic test_timing_extremes();
    set_timing(16'd1, 16'd1);
    hold_pattern(LEFT, 1); hold_pattern(NONE, 4);   // at-limit release at 1 tick
    hold_pattern(LEFT, 3); hold_pattern(NONE, 4);   // long, short lockout
    hold_pattern(MIDDLE, 1); hold_pattern(NONE, 1);
    set_timing(16'hFFFF, 16'hFFFF);
    hold_pattern(RIGHT, 100); hold_pattern(NONE, 1);   // short well under limit
  endtask

  // Mostly well-formed presses of random length around the limits, plus noise.
  task automatic run_random_presses(int n);
    int     stop_at;
    press_t p;
    stop_at = presses_sent + n;
    while (presses_sent < stop_at) begin
      if ($urandom_range(9, 0) < 7) begin
        p = press_t'(3'b100 >> $urandom_range(2, 0));
        hold_pattern(p, $urandom_range(long_limit + 3, 1));
        if ($urandom_range(3, 0) == 0)
          hold_pattern(p | press_t'($urandom_range(7, 0)), $urandom_range(3, 1));
        hold_pattern(NONE, $urandom_range(lockout_limit + 3, 1));
      end else begin
        repeat ($urandom_range(6, 1)) send_press(press_t'($urandom_range(7, 0)));
      end
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    set_timing(16'd3, 16'd2);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_off_left = 400;
    run_random_presses(80);
  endtask

  task automatic test_random_phases();
    set_timing(bpc_pkg::cfg_data_t'($urandom_range(12, 1)),
               bpc_pkg::cfg_data_t'($urandom_range(12, 1)));
    src_idle_pct = 0;  snk_stall_pct = 0;
    run_random_presses(RANDOM_ITEMS / 4);
    set_timing(bpc_pkg::cfg_data_t'($urandom_range(12, 1)),
               bpc_pkg::cfg_data_t'($urandom_range(12, 1)));
    src_idle_pct = 88; snk_stall_pct = 0;
    run_random_presses(RANDOM_ITEMS / 4);
    set_timing(bpc_pkg::cfg_data_t'($urandom_range(12, 1)),
               bpc_pkg::cfg_data_t'($urandom_range(12, 1)));
    src_idle_pct = 0;  snk_stall_pct = 88;
    run_random_presses(RANDOM_ITEMS / 4);
    set_timing(16'd1, 16'd1);
    src_idle_pct = 11; snk_stall_pct = 11;
    run_random_presses(RANDOM_ITEMS / 4);
  endtask

  initial begin
    btn_if.valid          = 1'b0;
    btn_if.left_pressed   = 1'b0;
    btn_if.middle_pressed = 1'b0;
    btn_if.right_pressed  = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = bpc_pkg::REG_LONG_PRESS;
    cfg_if.data           = '0;
    ev_if.ready           = 1'b0;
    long_limit            = bpc_pkg::LONG_PRESS_RESET;
    lockout_limit         = bpc_pkg::LOCKOUT_RESET;
    for (int i = 0; i < bpc_pkg::SLOTS; i++) begin
      armed[i]           = 1'b0;
      held_ticks[i]      = '0;
      held_after_long[i] = 1'b0;
      lockout_on[i]      = 1'b0;
      since_release[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_timing();
    test_directed();
    test_timing_extremes();
    test_backpressure();
    test_random_phases();
    drain_events();

    $display("Checked %0d event results from %0d button samples", events_checked,
             presses_sent);
    $display("Covered reset, extreme and random timings, idle/stall mixes, long stall");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
